// ----- design/edf_pkg.sv -----
package edf_pkg;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_SELECT = 2'd2;

  // list code forms the upper address bits of the shared list memory
  typedef enum logic [1:0] {
    LST_WAIT  = 2'd0,
    LST_READY = 2'd1,
    LST_FIFO  = 2'd2
  } list_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_realtime;
    logic [31:0] start_ms;
    logic [31:0] relative_deadline_ms;
    logic        still_running;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  task_id;
    logic        task_valid;
    logic        status;
    logic [31:0] deadlines_met;
    logic [31:0] deadlines_missed;
    logic [31:0] now_ms;
  } out_item_t;

endpackage

// ----- design/edf_ram.sv -----
module edf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/edf_slot_alloc.sv -----
module edf_slot_alloc #(
  parameter int MAX_TASKS = 16,
  localparam int IW = $clog2(MAX_TASKS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          set_i,
  input  logic [IW-1:0] set_idx_i,
  input  logic          clr_i,
  input  logic [IW-1:0] clr_idx_i,
  output logic          found_o,
  output logic [IW-1:0] idx_o
);

  logic [MAX_TASKS-1:0] busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      if (clr_i) begin
        busy_q[clr_idx_i] <= 1'b0;
      end
      if (set_i) begin
        busy_q[set_idx_i] <= 1'b1;
      end
    end
  end

  // lowest free slot wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

// ----- design/edf_realtime_task_scheduler.sv -----
// channel | signals                          | direction | transfer when
// input   | in_valid_i, in_stall_o, in_data_i   | in        | valid high, stall low
// output  | out_valid_o, out_stall_i, out_data_o | out       | valid high, stall low
//
// one item at a time. a tick advances the clock; a create files the new task: a background
// task goes to the fifo tail, a real-time one into the waiting or ready list by a walk.
// a select moves waiting tasks whose start has passed into the ready list, re-files the
// running task if it is still running or else retires it, then picks the ready head, or
// the fifo head if the ready list is empty.
// reset empties all lists and frees all slots at once, no clearing pass.
// a finished result sits in the output register; the next item is taken
// meanwhile and waits at its end only if that register is still stalled.
module edf_realtime_task_scheduler
  import edf_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int TB  = TIME_BITS;
  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int LAW = IW + 2;
  localparam int SW  = 2 * TB + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE, S_FILE, S_INS_RD, S_INS_SL, S_INS_CMP, S_REL_RD, S_REL_SL,
    S_REL_CMP, S_RUN_RD, S_RUN_CMP, S_PICK_RD, S_PICK_SET, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    CTX_CREATE, CTX_RELEASE, CTX_REFILE
  } ctx_e;

  function automatic logic [IW-1:0] ring(input logic [IW-1:0] h,
                                         input logic [IW:0] off);
    logic [IW+1:0] s;
    s = {2'b00, h} + {1'b0, off};
    if (s >= (IW+2)'(MAX_TASKS)) s = s - (IW+2)'(MAX_TASKS);
    return s[IW-1:0];
  endfunction

  state_e        state_q;
  ctx_e          ctx_q;
  logic          ins_rdy_q;
  logic [CW-1:0] pos_q;
  logic [IW-1:0] ent_q;
  logic [IW-1:0] cur_slot_q;
  logic          cur_rt_q;
  logic [TB-1:0] cur_st_q, cur_dl_q;
  logic          run_still_q;
  logic [TB-1:0] clock_q;
  logic [31:0]   met_q, miss_q;
  logic [IW-1:0] w_head_q, r_head_q, f_head_q;
  logic [CW-1:0] w_cnt_q, r_cnt_q, f_cnt_q;
  logic [IW-1:0] run_slot_q;
  logic          run_valid_q;
  logic [3:0]    res_id_q;
  logic          res_valid_q, res_status_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic           acc;
  logic [TB-1:0]  in_st, in_dl;
  logic           free_found;
  logic [IW-1:0]  free_idx;
  logic           s_we;
  logic [IW-1:0]  s_raddr;
  logic [SW-1:0]  s_wdata, s_rdata;
  logic           s_rt;
  logic [TB-1:0]  s_st, s_dl;
  logic           l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [IW-1:0]  l_wdata, l_rdata;
  list_e          isel;
  logic [IW-1:0]  ih;
  logic [CW-1:0]  ic;
  logic [TB-1:0]  cur_key, ent_key;
  logic           ent_less;
  logic           retire;
  state_e         fin_state;

  assign acc        = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_st      = TB'(in_data_i.start_ms);
  assign in_dl      = in_st + TB'(in_data_i.relative_deadline_ms);

  assign s_rt = s_rdata[2*TB];
  assign s_st = s_rdata[2*TB-1:TB];
  assign s_dl = s_rdata[TB-1:0];

  assign isel     = ins_rdy_q ? LST_READY : LST_WAIT;
  assign ih       = ins_rdy_q ? r_head_q : w_head_q;
  assign ic       = ins_rdy_q ? r_cnt_q : w_cnt_q;
  assign cur_key  = ins_rdy_q ? cur_dl_q : cur_st_q;
  assign ent_key  = ins_rdy_q ? s_dl : s_st;
  assign ent_less = ent_key < cur_key;

  assign s_we    = acc && (in_data_i.action == ACT_CREATE) && free_found;
  assign s_wdata = {in_data_i.is_realtime, in_st, in_dl};
  assign retire  = (state_q == S_RUN_CMP) && !run_still_q;

  always_comb begin
    case (ctx_q)
      CTX_RELEASE: fin_state = S_REL_RD;
      CTX_REFILE:  fin_state = S_PICK_RD;
      default:     fin_state = S_DONE;
    endcase
  end

  // memory port control
  always_comb begin
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    l_raddr = '0;
    s_raddr = '0;
    case (state_q)
      S_FILE: begin
        if (!cur_rt_q && (f_cnt_q < CNT_MAX)) begin
          l_we    = 1'b1;
          l_waddr = {LST_FIFO, ring(f_head_q, (IW+1)'(f_cnt_q))};
          l_wdata = cur_slot_q;
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          l_we    = 1'b1;
          l_waddr = {isel, ih};
          l_wdata = cur_slot_q;
        end else begin
          l_raddr = {isel, ring(ih, (IW+1)'(pos_q - CW'(1)))};
        end
      end
      S_INS_SL: s_raddr = l_rdata;
      S_INS_CMP: begin
        l_we    = 1'b1;
        l_waddr = {isel, ring(ih, (IW+1)'(pos_q))};
        l_wdata = ent_less ? cur_slot_q : ent_q;
      end
      S_REL_RD: l_raddr = {LST_WAIT, w_head_q};
      S_REL_SL: s_raddr = l_rdata;
      S_RUN_RD: s_raddr = run_slot_q;
      S_PICK_RD: begin
        if (r_cnt_q != '0) begin
          l_raddr = {LST_READY, r_head_q};
        end else begin
          l_raddr = {LST_FIFO, f_head_q};
        end
      end
      default: ;
    endcase
  end

  edf_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (free_idx),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  edf_ram #(.WIDTH(IW), .DEPTH(4 * (2 ** IW))) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  edf_slot_alloc #(.MAX_TASKS(MAX_TASKS)) u_alloc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .set_i     (s_we),
    .set_idx_i (free_idx),
    .clr_i     (retire),
    .clr_idx_i (run_slot_q),
    .found_o   (free_found),
    .idx_o     (free_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ctx_q        <= CTX_CREATE;
      ins_rdy_q    <= 1'b0;
      pos_q        <= '0;
      ent_q        <= '0;
      cur_slot_q   <= '0;
      cur_rt_q     <= 1'b0;
      cur_st_q     <= '0;
      cur_dl_q     <= '0;
      run_still_q  <= 1'b0;
      clock_q      <= '0;
      met_q        <= '0;
      miss_q       <= '0;
      w_head_q     <= '0;
      r_head_q     <= '0;
      f_head_q     <= '0;
      w_cnt_q      <= '0;
      r_cnt_q      <= '0;
      f_cnt_q      <= '0;
      run_slot_q   <= '0;
      run_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            res_id_q     <= '0;
            res_valid_q  <= 1'b0;
            res_status_q <= 1'b0;
            state_q      <= S_DONE;
            case (in_data_i.action)
              ACT_TICK: clock_q <= clock_q + TB'(1);
              ACT_CREATE: begin
                if (!free_found) begin
                  res_status_q <= 1'b1;
                end else begin
                  cur_slot_q  <= free_idx;
                  cur_rt_q    <= in_data_i.is_realtime;
                  cur_st_q    <= in_st;
                  cur_dl_q    <= in_dl;
                  res_id_q    <= 4'(free_idx);
                  res_valid_q <= 1'b1;
                  ctx_q       <= CTX_CREATE;
                  state_q     <= S_FILE;
                end
              end
              ACT_SELECT: begin
                run_still_q <= in_data_i.still_running;
                state_q     <= S_REL_RD;
              end
              default: ;
            endcase
          end
        end
        S_FILE: begin
          if (cur_rt_q) begin
            ins_rdy_q <= !(clock_q < cur_st_q);
            if (clock_q < cur_st_q) begin
              pos_q   <= w_cnt_q;
              state_q <= (w_cnt_q < CNT_MAX) ? S_INS_RD : fin_state;
            end else begin
              pos_q   <= r_cnt_q;
              state_q <= (r_cnt_q < CNT_MAX) ? S_INS_RD : fin_state;
            end
          end else begin
            if (f_cnt_q < CNT_MAX) begin
              f_cnt_q <= f_cnt_q + CW'(1);
            end
            state_q <= fin_state;
          end
        end
        S_INS_RD: begin
          if (pos_q == '0) begin
            if (ins_rdy_q) r_cnt_q <= r_cnt_q + CW'(1);
            else           w_cnt_q <= w_cnt_q + CW'(1);
            state_q <= fin_state;
          end else begin
            state_q <= S_INS_SL;
          end
        end
        S_INS_SL: begin
          ent_q   <= l_rdata;
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          // tail-first walk: shift entries up until a smaller key is met
          if (ent_less) begin
            if (ins_rdy_q) r_cnt_q <= r_cnt_q + CW'(1);
            else           w_cnt_q <= w_cnt_q + CW'(1);
            state_q <= fin_state;
          end else begin
            pos_q   <= pos_q - CW'(1);
            state_q <= S_INS_RD;
          end
        end
        S_REL_RD: state_q <= (w_cnt_q != '0) ? S_REL_SL : S_RUN_RD;
        S_REL_SL: begin
          ent_q   <= l_rdata;
          state_q <= S_REL_CMP;
        end
        S_REL_CMP: begin
          if (s_st < clock_q) begin
            w_head_q   <= ring(w_head_q, (IW+1)'(1));
            w_cnt_q    <= w_cnt_q - CW'(1);
            cur_slot_q <= ent_q;
            cur_rt_q   <= s_rt;
            cur_st_q   <= s_st;
            cur_dl_q   <= s_dl;
            ctx_q      <= CTX_RELEASE;
            state_q    <= S_FILE;
          end else begin
            state_q <= S_RUN_RD;
          end
        end
        S_RUN_RD: state_q <= run_valid_q ? S_RUN_CMP : S_PICK_RD;
        S_RUN_CMP: begin
          if (run_still_q) begin
            cur_slot_q <= run_slot_q;
            cur_rt_q   <= s_rt;
            cur_st_q   <= s_st;
            cur_dl_q   <= s_dl;
            ctx_q      <= CTX_REFILE;
            state_q    <= S_FILE;
          end else begin
            if (s_rt) begin
              if (s_dl > clock_q) met_q  <= met_q + 32'd1;
              else                miss_q <= miss_q + 32'd1;
            end
            state_q <= S_PICK_RD;
          end
        end
        S_PICK_RD: begin
          run_valid_q <= 1'b0;
          run_slot_q  <= '0;
          if ((r_cnt_q != '0) || (f_cnt_q != '0)) begin
            state_q <= S_PICK_SET;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PICK_SET: begin
          run_slot_q  <= l_rdata;
          run_valid_q <= 1'b1;
          res_id_q    <= 4'(l_rdata);
          res_valid_q <= 1'b1;
          if (r_cnt_q != '0) begin
            r_head_q <= ring(r_head_q, (IW+1)'(1));
            r_cnt_q  <= r_cnt_q - CW'(1);
          end else begin
            f_head_q <= ring(f_head_q, (IW+1)'(1));
            f_cnt_q  <= f_cnt_q - CW'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_q.task_id          <= res_id_q;
            out_q.task_valid       <= res_valid_q;
            out_q.status           <= res_status_q;
            out_q.deadlines_met    <= met_q;
            out_q.deadlines_missed <= miss_q;
            out_q.now_ms           <= 32'(clock_q);
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/edf_sched_chk.sv -----
module edf_sched_chk
  import edf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic        seen_q;
  logic [31:0] met_q, miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      met_q  <= '0;
      miss_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      seen_q <= 1'b1;
      met_q  <= out_data_o.deadlines_met;
      miss_q <= out_data_o.deadlines_missed;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: input stalls right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // one select retires at most one task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q |->
      (32'(out_data_o.deadlines_met - met_q) +
       32'(out_data_o.deadlines_missed - miss_q)) <= 32'd1)
    else $error("deadline counters jumped");

  // a refused create names no task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      !out_data_o.task_valid && (out_data_o.task_id == 4'd0))
    else $error("refused create carries a task");

endmodule

bind edf_realtime_task_scheduler edf_sched_chk u_edf_chk (.*);
